// ===== src/sha256sh_pkg.sv =====
// Package: payload types, state codes, constants and schedule functions for the SHA-256 hasher.
package sha256sh_pkg;

    localparam int unsigned WordW     = 32;
    localparam int unsigned SchedDepth = 16;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef logic [7:0][31:0] hvec_t;

    typedef enum logic [2:0] {
        S_FILL, S_PINIT, S_PAD, S_CMP, S_ADD, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        R_FILL, R_PAD, R_PAD2, R_OUT
    } ret_t;

    localparam hvec_t HashInit = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [0:63][31:0] RoundK = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== src/sha256_stream_hasher.sv =====
// Top level: byte-stream SHA-256 hasher with RAM-held block and message schedule.
//
//  channel | dir | ports                         | payload
//  s_      | in  | s_valid s_ready s_payload     | msg_byte, byte_present, end_of_message
//  m_      | out | m_valid m_ready m_payload     | digest_word, word_index, last_word
//
// One byte per cycle while filling; a full block is then compressed in 64 rounds,
// each a read phase and an update phase paced by the two-read schedule RAM, then a hash add.
// End of message: a set-up state, 16 - held/4 pad writes, a compression per padded block,
// 16 more pad writes for a spill block, then 8 output transfers.
// Synchronous active-low reset restores the initial hash; RAM contents are not cleared.
// Input stalls while a block is compressed, padded or the digest is out.
module sha256_stream_hasher (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  sha256sh_pkg::in_item_t  s_payload,
    output logic                    m_valid,
    input  logic                    m_ready,
    output sha256sh_pkg::out_item_t m_payload
);

    sha256sh_pkg::state_t state_reg, state_next;
    sha256sh_pkg::ret_t   ret_reg, ret_next;
    sha256sh_pkg::hvec_t  hash_reg, hash_next;
    sha256sh_pkg::hvec_t  v_reg, v_next, v_rnd;

    logic [5:0]  cnt_reg, cnt_next;
    logic [23:0] acc_reg, acc_next;
    logic [63:0] bits_reg, bits_next;
    logic [63:0] total_reg, total_next;
    logic [3:0]  ptr_reg, ptr_next;
    logic [3:0]  kw_reg, kw_next;
    logic        two_reg, two_next;
    logic        first_reg, first_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic        ph_reg, ph_next;
    logic        pend_reg, pend_next;
    logic [31:0] s1_reg, s1_next;
    logic [31:0] s0_reg, s0_next;
    logic [2:0]  idx_reg, idx_next;

    logic        we;
    logic [3:0]  waddr;
    logic [31:0] wdata;
    logic [3:0]  raddr_a;
    logic [3:0]  raddr_b;
    logic [31:0] rdata_a;
    logic [31:0] rdata_b;
    logic [5:0]  tc;
    logic [31:0] w_rnd;
    logic [31:0] part_word;
    logic        in_xfer;

    sha256sh_ram #(
        .WIDTH (sha256sh_pkg::WordW),
        .DEPTH (sha256sh_pkg::SchedDepth)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign tc = 6'(rnd_reg - 7'd1);

    sha256sh_round u_round (
        .v_i   (v_reg),
        .early (tc[5:4] == 2'd0),
        .rd_a  (rdata_a),
        .rd_b  (rdata_b),
        .s1    (s1_reg),
        .s0    (s0_reg),
        .k     (sha256sh_pkg::RoundK[tc]),
        .v_o   (v_rnd),
        .w_o   (w_rnd)
    );

    assign s_ready = (state_reg == sha256sh_pkg::S_FILL);
    assign in_xfer = s_valid && s_ready;
    assign m_valid = (state_reg == sha256sh_pkg::S_OUT);
    assign m_payload.digest_word = hash_reg[idx_reg];
    assign m_payload.word_index  = idx_reg;
    assign m_payload.last_word   = (idx_reg == 3'd7);

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    part_word = 32'h8000_0000;
            2'd1:    part_word = {acc_reg[7:0], 8'h80, 16'h0};
            2'd2:    part_word = {acc_reg[15:0], 8'h80, 8'h0};
            default: part_word = {acc_reg[23:0], 8'h80};
        endcase
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        hash_next  = hash_reg;
        v_next     = v_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        bits_next  = bits_reg;
        total_next = total_reg;
        ptr_next   = ptr_reg;
        kw_next    = kw_reg;
        two_next   = two_reg;
        first_next = first_reg;
        rnd_next   = rnd_reg;
        ph_next    = ph_reg;
        pend_next  = pend_reg;
        s1_next    = s1_reg;
        s0_next    = s0_reg;
        idx_next   = idx_reg;
        we         = 1'b0;
        waddr      = cnt_reg[5:2];
        wdata      = {acc_reg, s_payload.msg_byte};
        raddr_a    = 4'(rnd_reg[3:0] - 4'd2);
        raddr_b    = 4'(rnd_reg[3:0] + 4'd1);
        case (state_reg)
            sha256sh_pkg::S_FILL: begin
                if (in_xfer) begin
                    if (s_payload.byte_present) begin
                        acc_next = {acc_reg[15:0], s_payload.msg_byte};
                        cnt_next = 6'(cnt_reg + 6'd1);
                        we       = (cnt_reg[1:0] == 2'd3);
                        if (cnt_reg == 6'd63) begin
                            bits_next  = bits_reg + 64'd512;
                            state_next = sha256sh_pkg::S_CMP;
                            ret_next   = s_payload.end_of_message ? sha256sh_pkg::R_PAD
                                                                  : sha256sh_pkg::R_FILL;
                            rnd_next   = 7'd0;
                            ph_next    = 1'b0;
                            pend_next  = 1'b0;
                        end else if (s_payload.end_of_message) begin
                            state_next = sha256sh_pkg::S_PINIT;
                        end
                    end else if (s_payload.end_of_message) begin
                        state_next = sha256sh_pkg::S_PINIT;
                    end
                end
            end
            sha256sh_pkg::S_PINIT: begin
                total_next = bits_reg + {55'd0, cnt_reg, 3'd0};
                kw_next    = cnt_reg[5:2];
                ptr_next   = cnt_reg[5:2];
                two_next   = (cnt_reg >= 6'd56);
                first_next = 1'b1;
                state_next = sha256sh_pkg::S_PAD;
            end
            sha256sh_pkg::S_PAD: begin
                we    = 1'b1;
                waddr = ptr_reg;
                if (first_reg && ptr_reg == kw_reg) begin
                    wdata = part_word;
                end else if (!(first_reg && two_reg) && ptr_reg == 4'd14) begin
                    wdata = total_reg[63:32];
                end else if (!(first_reg && two_reg) && ptr_reg == 4'd15) begin
                    wdata = total_reg[31:0];
                end else begin
                    wdata = 32'd0;
                end
                ptr_next = 4'(ptr_reg + 4'd1);
                if (ptr_reg == 4'd15) begin
                    state_next = sha256sh_pkg::S_CMP;
                    ret_next   = (first_reg && two_reg) ? sha256sh_pkg::R_PAD2
                                                        : sha256sh_pkg::R_OUT;
                    rnd_next   = 7'd0;
                    ph_next    = 1'b0;
                    pend_next  = 1'b0;
                end
            end
            sha256sh_pkg::S_CMP: begin
                if (!ph_reg) begin
                    if (pend_reg) begin
                        v_next = v_rnd;
                        we     = (tc[5:4] != 2'd0);
                        waddr  = tc[3:0];
                        wdata  = w_rnd;
                    end else begin
                        v_next = hash_reg;
                    end
                    if (rnd_reg == 7'd64) begin
                        state_next = sha256sh_pkg::S_ADD;
                    end else begin
                        ph_next = 1'b1;
                    end
                end else begin
                    s1_next   = sha256sh_pkg::ssig1(rdata_a);
                    s0_next   = sha256sh_pkg::ssig0(rdata_b);
                    raddr_a   = 4'(rnd_reg[3:0] + 4'd9);
                    raddr_b   = rnd_reg[3:0];
                    ph_next   = 1'b0;
                    pend_next = 1'b1;
                    rnd_next  = 7'(rnd_reg + 7'd1);
                end
            end
            sha256sh_pkg::S_ADD: begin
                for (int j = 0; j < 8; j++) begin
                    hash_next[j] = hash_reg[j] + v_reg[j];
                end
                case (ret_reg)
                    sha256sh_pkg::R_FILL: state_next = sha256sh_pkg::S_FILL;
                    sha256sh_pkg::R_PAD:  state_next = sha256sh_pkg::S_PINIT;
                    sha256sh_pkg::R_PAD2: begin
                        state_next = sha256sh_pkg::S_PAD;
                        first_next = 1'b0;
                        ptr_next   = 4'd0;
                    end
                    default: begin
                        state_next = sha256sh_pkg::S_OUT;
                        idx_next   = 3'd0;
                    end
                endcase
            end
            sha256sh_pkg::S_OUT: begin
                if (m_ready) begin
                    idx_next = 3'(idx_reg + 3'd1);
                    if (idx_reg == 3'd7) begin
                        hash_next  = sha256sh_pkg::HashInit;
                        bits_next  = 64'd0;
                        cnt_next   = 6'd0;
                        state_next = sha256sh_pkg::S_FILL;
                    end
                end
            end
            default: state_next = sha256sh_pkg::S_FILL;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha256sh_pkg::S_FILL;
            ret_reg   <= sha256sh_pkg::R_FILL;
            hash_reg  <= sha256sh_pkg::HashInit;
            cnt_reg   <= 6'd0;
            bits_reg  <= 64'd0;
            rnd_reg   <= 7'd0;
            ph_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            idx_reg   <= 3'd0;
            ptr_reg   <= 4'd0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            hash_reg  <= hash_next;
            cnt_reg   <= cnt_next;
            bits_reg  <= bits_next;
            rnd_reg   <= rnd_next;
            ph_reg    <= ph_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
            ptr_reg   <= ptr_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg     <= v_next;
        acc_reg   <= acc_next;
        total_reg <= total_next;
        kw_reg    <= kw_next;
        two_reg   <= two_next;
        s1_reg    <= s1_next;
        s0_reg    <= s0_next;
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output open together");

    a_back_to_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_payload.last_word) |=> (s_ready && cnt_reg == 6'd0))
        else $error("no restart after digest");

    a_no_write_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !we)
        else $error("RAM write while digest out");

    a_round_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sha256sh_pkg::S_CMP) |-> (rnd_reg <= 7'd64))
        else $error("round counter overrun");

endmodule

// ===== src/sha256sh_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module sha256sh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== src/sha256sh_round.sv =====
// One SHA-256 round: schedule word assembly and working-variable update.
module sha256sh_round (
    input  sha256sh_pkg::hvec_t v_i,
    input  logic                early,
    input  logic [31:0]         rd_a,
    input  logic [31:0]         rd_b,
    input  logic [31:0]         s1,
    input  logic [31:0]         s0,
    input  logic [31:0]         k,
    output sha256sh_pkg::hvec_t v_o,
    output logic [31:0]         w_o
);

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] a;
    logic [31:0] e;

    assign a   = v_i[0];
    assign e   = v_i[4];
    assign w_o = early ? rd_b : (s1 + rd_a + s0 + rd_b);
    assign t1  = v_i[7]
               + (sha256sh_pkg::rotr(e, 6) ^ sha256sh_pkg::rotr(e, 11)
                  ^ sha256sh_pkg::rotr(e, 25))
               + ((e & v_i[5]) ^ (~e & v_i[6])) + k + w_o;
    assign t2  = (sha256sh_pkg::rotr(a, 2) ^ sha256sh_pkg::rotr(a, 13)
                  ^ sha256sh_pkg::rotr(a, 22))
               + ((a & v_i[1]) ^ (a & v_i[2]) ^ (v_i[1] & v_i[2]));

    always_comb begin
        v_o    = v_i;
        v_o[7] = v_i[6];
        v_o[6] = v_i[5];
        v_o[5] = v_i[4];
        v_o[4] = v_i[3] + t1;
        v_o[3] = v_i[2];
        v_o[2] = v_i[1];
        v_o[1] = v_i[0];
        v_o[0] = t1 + t2;
    end

endmodule

// ===== dv/sha256_stream_hasher_test.sv =====
// Testbench: streams byte messages into the SHA-256 hasher and checks every digest word.
module sha256_stream_hasher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 1200000;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    sha256sh_pkg::in_item_t  s_payload;
    logic                    m_valid;
    logic                    m_ready;
    sha256sh_pkg::out_item_t m_payload;

    sha256_stream_hasher DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    localparam logic [31:0] IvWords [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] KTab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    sha256sh_pkg::in_item_t  pending_items[$];
    sha256sh_pkg::out_item_t digest_words_due[$];
    logic [7:0]  blk_bytes [64];
    logic [5:0]  blk_fill;
    logic [63:0] bits_done;
    logic [31:0] hash_acc [8];
    bit          failed;
    bit          stim_done;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned hold_left;
    int unsigned stall_phase;

    function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_into_hash();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        v = hash_acc;
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                s1 = ror32(w[(t-2)&15], 17) ^ ror32(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
                s0 = ror32(w[(t-15)&15], 7) ^ ror32(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
                wt = s1 + w[(t-7)&15] + s0 + w[t&15];
                w[t&15] = wt;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[t] + wt;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_acc[i] += v[i];
    endtask

    task automatic predict_digest(sha256sh_pkg::in_item_t it);
        int unsigned i;
        logic [63:0] total;
        sha256sh_pkg::out_item_t o;
        if (it.byte_present) begin
            blk_bytes[blk_fill] = it.msg_byte;
            blk_fill++;
            if (blk_fill == 0) begin
                compress_into_hash();
                bits_done += 64'd512;
            end
        end
        if (!it.end_of_message) return;
        i = blk_fill;
        total = bits_done + 64'(i) * 8;
        blk_bytes[i] = 8'h80;
        i++;
        if (i > 56) begin
            while (i < 64) begin blk_bytes[i] = 8'h00; i++; end
            compress_into_hash();
            i = 0;
        end
        while (i < 56) begin blk_bytes[i] = 8'h00; i++; end
        for (int b = 0; b < 8; b++) blk_bytes[63-b] = total[8*b +: 8];
        compress_into_hash();
        for (int k = 0; k < 8; k++) begin
            o.digest_word = hash_acc[k];
            o.word_index = 3'(k);
            o.last_word = (k == 7);
            digest_words_due.push_back(o);
        end
        blk_fill = '0;
        bits_done = '0;
        hash_acc = IvWords;
    endtask

    function automatic sha256sh_pkg::in_item_t make_item(bit has_byte, logic [7:0] b, bit fin);
        sha256sh_pkg::in_item_t it;
        it.msg_byte = b;
        it.byte_present = has_byte;
        it.end_of_message = fin;
        return it;
    endfunction

    task automatic queue_message(int unsigned len, bit end_with_byte, bit zeros);
        for (int unsigned n = 0; n < len; n++) begin
            bit fin;
            fin = end_with_byte && (n == len - 1);
            pending_items.push_back(make_item(1'b1,
                zeros ? 8'h00 : 8'($urandom_range(0, 255)), fin));
            if ($urandom_range(0, 19) == 0)
                pending_items.push_back(make_item(1'b0, 8'($urandom), 1'b0));
        end
        if (!end_with_byte || len == 0)
            pending_items.push_back(make_item(1'b0, 8'($urandom), 1'b1));
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        int unsigned len;
        aresetn = 1'b0;
        blk_fill = '0;
        bits_done = '0;
        hash_acc = IvWords;
        for (int i = 0; i < 64; i++) blk_bytes[i] = '0;
        // directed: empty, idle item, byte+end, 0xff, zero bytes, padding boundaries
        queue_message(0, 1'b0, 1'b0);
        pending_items.push_back(make_item(1'b0, 8'hff, 1'b0));
        pending_items.push_back(make_item(1'b1, 8'hff, 1'b1));
        pending_items.push_back(make_item(1'b1, 8'h00, 1'b0));
        pending_items.push_back(make_item(1'b1, 8'h00, 1'b0));
        pending_items.push_back(make_item(1'b0, 8'h00, 1'b1));
        queue_message(3, 1'b1, 1'b0);
        queue_message(55, 1'b1, 1'b0);
        queue_message(56, 1'b0, 1'b1);
        queue_message(64, 1'b1, 1'b0);
        while (pending_items.size() < 470) begin
            case ($urandom_range(0, 5))
                0:       len = $urandom_range(54, 57);
                1:       len = $urandom_range(62, 66);
                2:       len = $urandom_range(0, 3);
                default: len = $urandom_range(0, 140);
            endcase
            queue_message(len, $urandom_range(0, 1), $urandom_range(0, 15) == 0);
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // sender: bursts with gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_payload <= '0;
            burst_left <= 0;
            gap_left <= 0;
            stim_done <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_digest(s_payload);
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    s_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_items.size() == 0) begin
                    s_valid <= 1'b0;
                    stim_done <= 1'b1;
                end else begin
                    s_valid <= 1'b1;
                    s_payload <= pending_items.pop_front();
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // receiver: own stall pattern, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_phase <= 0;
            hold_left <= 3000;
        end else begin
            stall_phase <= stall_phase + 1;
            if (cycle_count > 2000 && hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (stall_phase[9:8] == 2'b11) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= $urandom_range(0, 2) != 0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        sha256sh_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (digest_words_due.size() == 0) begin
                $error("unexpected digest transfer %h", m_payload);
                failed = 1'b1;
            end else begin
                want = digest_words_due.pop_front();
                if (m_payload.digest_word !== want.digest_word) begin
                    $error("digest_word exp %h got %h", want.digest_word, m_payload.digest_word);
                    failed = 1'b1;
                end
                if (m_payload.word_index !== want.word_index) begin
                    $error("word_index exp %0d got %0d", want.word_index, m_payload.word_index);
                    failed = 1'b1;
                end
                if (m_payload.last_word !== want.last_word) begin
                    $error("last_word exp %0d got %0d", want.last_word, m_payload.last_word);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        failed = 1'b0;
        cycle_count = 0;
        while (!(stim_done && digest_words_due.size() == 0) && cycle_count < CycleLimit) begin
            @(posedge aclk);
            cycle_count++;
        end
        if (cycle_count >= CycleLimit) begin
            $display("FAILED: results differ");
        end else begin
            repeat (300) @(posedge aclk);
            if (!failed) begin
                $display("PASSED: all results match");
            end else begin
                $display("FAILED: results differ");
            end
        end
        $finish;
    end

endmodule
